// File: design/bags_pkg.sv
// shared types and constants for the bilinear argb grid sampler
// no dependencies; used by bags_coord and bilinear_argb_grid_sampler
package bags_pkg;

	localparam int MAX_COLUMNS_DEF   = 256;
	localparam int MAX_ROWS_DEF      = 256;
	localparam int FRACTION_BITS_DEF = 8;

	localparam int CFG_W       = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_COUNT_W = 9;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP_X   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP_Y   = 3'd5;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	localparam int PIX_W  = 32;
	localparam int CH_W   = 8;
	localparam int NUM_CH = 4;
	localparam logic [PIX_W-1:0] INVALID_COLOR = 32'hFFFF_FFFF;

	// position Q24.8, step reciprocal Q16.16
	localparam int POS_FRAC_W = 8;
	localparam int INV_FRAC_W = 16;
	localparam int DIFF_W     = 33;
	localparam int SPLIT_W    = 16;
	localparam int PROD_W     = 66;

	typedef struct packed {
		logic               command;
		logic [7:0]         column;
		logic [7:0]         row;
		logic [31:0]        pixel_argb;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
	} bags_in_t;

	typedef struct packed {
		logic [31:0] color_argb;
		logic        valid_res;
	} bags_out_t;

endpackage

// File: design/bags_coord.sv
// map-to-grid coordinate unit: three-stage split multiply, floor shift, row flip
// depends on bags_pkg
module bags_coord #(
	parameter int FRACTION_BITS = bags_pkg::FRACTION_BITS_DEF,
	parameter int ROW_CNT_W     = bags_pkg::CFG_COUNT_W
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    go,
	input  logic signed [bags_pkg::DIFF_W-1:0]      dx,
	input  logic signed [bags_pkg::DIFF_W-1:0]      dy,
	input  logic [bags_pkg::CFG_W-1:0]              inv_x,
	input  logic [bags_pkg::CFG_W-1:0]              inv_y,
	input  logic [ROW_CNT_W-1:0]                    rows_eff,
	output logic                                    ack,
	output logic signed [bags_pkg::PROD_W - (bags_pkg::POS_FRAC_W + bags_pkg::INV_FRAC_W
		- FRACTION_BITS):0] cx,
	output logic signed [bags_pkg::PROD_W - (bags_pkg::POS_FRAC_W + bags_pkg::INV_FRAC_W
		- FRACTION_BITS):0] cy
);

	localparam int SCALE_SHIFT = bags_pkg::POS_FRAC_W + bags_pkg::INV_FRAC_W - FRACTION_BITS;
	localparam int CW          = bags_pkg::PROD_W - SCALE_SHIFT + 1;
	localparam int LO_W        = bags_pkg::SPLIT_W;
	localparam int HI_W        = bags_pkg::DIFF_W - LO_W;
	localparam int PP_W        = HI_W + bags_pkg::CFG_W + 1;
	localparam int PW          = bags_pkg::PROD_W;

	logic signed [PP_W-1:0] xlo_s1, xhi_s1, ylo_s1, yhi_s1;
	logic signed [PW-1:0]   px_s2, py_s2;
	logic signed [CW-1:0]   cx_s3, cy_s3;
	logic signed [CW-1:0]   row_base;
	logic                   v_s1, v_s2, v_s3;

	assign row_base = (CW'(rows_eff) - CW'(1)) << FRACTION_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= go;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			xlo_s1 <= $signed({1'b0, dx[LO_W-1:0]}) * $signed({1'b0, inv_x});
			xhi_s1 <= $signed(dx[bags_pkg::DIFF_W-1:LO_W]) * $signed({1'b0, inv_x});
			ylo_s1 <= $signed({1'b0, dy[LO_W-1:0]}) * $signed({1'b0, inv_y});
			yhi_s1 <= $signed(dy[bags_pkg::DIFF_W-1:LO_W]) * $signed({1'b0, inv_y});
		end
		if (v_s1) begin
			px_s2 <= (PW'(xhi_s1) <<< LO_W) + PW'(xlo_s1);
			py_s2 <= (PW'(yhi_s1) <<< LO_W) + PW'(ylo_s1);
		end
		if (v_s2) begin
			cx_s3 <= CW'(px_s2 >>> SCALE_SHIFT);
			cy_s3 <= row_base - CW'(py_s2 >>> SCALE_SHIFT);
		end
	end

	assign ack = v_s3;
	assign cx  = cx_s3;
	assign cy  = cy_s3;

endmodule

// File: design/bilinear_argb_grid_sampler.sv
// bilinear argb grid sampler top level: config registers, pixel memory, sequencer, blend
// depends on bags_pkg and bags_coord
// a write beat never raises busy; a sample beat shows done once the coordinate unit, the
// range check and four corner reads finish (the check alone when a corner lies outside the grid)
// busy holds off a new sample until done (3-stage coordinate multiply, four single-port reads)
// reset clears the sequencer and loads config defaults, not pixel memory; receiver cannot stall
module bilinear_argb_grid_sampler #(
	parameter int MAX_COLUMNS   = bags_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS      = bags_pkg::MAX_ROWS_DEF,
	parameter int FRACTION_BITS = bags_pkg::FRACTION_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  bags_pkg::bags_in_t                request,
	output logic                              done,
	output bags_pkg::bags_out_t               result,
	input  logic                              cfg_we,
	input  logic [bags_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bags_pkg::CFG_W-1:0]        cfg_data
);

	localparam int COL_IDX_W   = $clog2(MAX_COLUMNS);
	localparam int ROW_IDX_W   = $clog2(MAX_ROWS);
	localparam int DEPTH       = MAX_COLUMNS * MAX_ROWS;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int COL_CNT_W   = ($clog2(MAX_COLUMNS + 1) > bags_pkg::CFG_COUNT_W) ?
		$clog2(MAX_COLUMNS + 1) : bags_pkg::CFG_COUNT_W;
	localparam int ROW_CNT_W   = ($clog2(MAX_ROWS + 1) > bags_pkg::CFG_COUNT_W) ?
		$clog2(MAX_ROWS + 1) : bags_pkg::CFG_COUNT_W;
	localparam int SCALE_SHIFT = bags_pkg::POS_FRAC_W + bags_pkg::INV_FRAC_W - FRACTION_BITS;
	localparam int CW          = bags_pkg::PROD_W - SCALE_SHIFT + 1;
	localparam int W_W         = 2 * FRACTION_BITS + 1;
	localparam int ACC_W       = 2 * FRACTION_BITS + bags_pkg::CH_W;
	localparam int CW_W        = bags_pkg::CH_W;
	localparam int NCH         = bags_pkg::NUM_CH;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_COORD = 8'b0000_0010,
		ST_CHECK = 8'b0000_0100,
		ST_RD0   = 8'b0000_1000,
		ST_RD1   = 8'b0001_0000,
		ST_RD2   = 8'b0010_0000,
		ST_RD3   = 8'b0100_0000,
		ST_FIN   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	logic [bags_pkg::CFG_COUNT_W-1:0] grid_columns_q, grid_rows_q;
	logic signed [bags_pkg::CFG_W-1:0] origin_x_q, origin_y_q;
	logic [bags_pkg::CFG_W-1:0]        inv_step_x_q, inv_step_y_q;
	logic [COL_CNT_W-1:0]              cols_eff;
	logic [ROW_CNT_W-1:0]              rows_eff;

	logic accept, acc_wr, acc_smp, wr_in_range;
	logic signed [bags_pkg::DIFF_W-1:0] dx_q, dy_q;
	logic go_q, coord_ack;
	logic signed [CW-1:0] cx, cy;

	logic [FRACTION_BITS-1:0] t, u;
	logic [FRACTION_BITS:0]   omt, omu, ft, fu;
	logic [COL_CNT_W:0]       i1x;
	logic [ROW_CNT_W:0]       j1y;
	logic                     ok_x, ok_y, ok;
	logic [2*FRACTION_BITS+1:0] wprod [NCH];
	logic [W_W-1:0]           w_q [NCH];
	logic [COL_IDX_W-1:0]     col0_q, col1_q;
	logic [ROW_IDX_W-1:0]     row0_q, row1_q;

	logic [bags_pkg::PIX_W-1:0] pix_mem [DEPTH];
	logic [bags_pkg::PIX_W-1:0] rd_q;
	logic [ADDR_W-1:0]          mem_addr;
	logic                       mem_we, mem_re;

	logic [W_W-1:0]           corner_w;
	logic [W_W+CW_W-1:0]      prod [NCH];
	logic [ACC_W-1:0]         sum_next [NCH];
	logic [ACC_W-1:0]         acc_q [NCH];
	logic [bags_pkg::PIX_W-1:0] blend_color;

	logic                done_q;
	bags_pkg::bags_out_t result_q;

	function automatic logic [ADDR_W-1:0] pix_addr(input logic [ROW_IDX_W-1:0] r,
		input logic [COL_IDX_W-1:0] c);
		return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_COLUMNS)) + ADDR_W'(c);
	endfunction

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_columns_q <= bags_pkg::CFG_COUNT_W'(256);
			grid_rows_q    <= bags_pkg::CFG_COUNT_W'(256);
			origin_x_q     <= '0;
			origin_y_q     <= '0;
			inv_step_x_q   <= 32'd65536;
			inv_step_y_q   <= 32'd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bags_pkg::CFG_GRID_COLUMNS: begin
					grid_columns_q <= cfg_data[bags_pkg::CFG_COUNT_W-1:0];
				end
				bags_pkg::CFG_GRID_ROWS: begin
					grid_rows_q <= cfg_data[bags_pkg::CFG_COUNT_W-1:0];
				end
				bags_pkg::CFG_ORIGIN_X:   origin_x_q   <= $signed(cfg_data);
				bags_pkg::CFG_ORIGIN_Y:   origin_y_q   <= $signed(cfg_data);
				bags_pkg::CFG_INV_STEP_X: inv_step_x_q <= cfg_data;
				bags_pkg::CFG_INV_STEP_Y: inv_step_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cols_eff = (COL_CNT_W'(grid_columns_q) > COL_CNT_W'(MAX_COLUMNS)) ?
		COL_CNT_W'(MAX_COLUMNS) : COL_CNT_W'(grid_columns_q);
	assign rows_eff = (ROW_CNT_W'(grid_rows_q) > ROW_CNT_W'(MAX_ROWS)) ?
		ROW_CNT_W'(MAX_ROWS) : ROW_CNT_W'(grid_rows_q);

	assign busy        = (state_q != ST_IDLE);
	assign accept      = start && !busy;
	assign acc_wr      = accept && (request.command == bags_pkg::CMD_WRITE);
	assign acc_smp     = accept && (request.command == bags_pkg::CMD_SAMPLE);
	assign wr_in_range = (32'(request.column) < MAX_COLUMNS) && (32'(request.row) < MAX_ROWS);

	always_ff @(posedge clk) begin
		if (acc_smp) begin
			dx_q <= bags_pkg::DIFF_W'(request.pos_x) - bags_pkg::DIFF_W'(origin_x_q);
			dy_q <= bags_pkg::DIFF_W'(request.pos_y) - bags_pkg::DIFF_W'(origin_y_q);
		end
	end

	bags_coord #(
		.FRACTION_BITS (FRACTION_BITS),
		.ROW_CNT_W     (ROW_CNT_W)
	) u_coord (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go_q),
		.dx       (dx_q),
		.dy       (dy_q),
		.inv_x    (inv_step_x_q),
		.inv_y    (inv_step_y_q),
		.rows_eff (rows_eff),
		.ack      (coord_ack),
		.cx       (cx),
		.cy       (cy)
	);

	// corner range check and weights
	always_comb begin
		t    = cx[FRACTION_BITS-1:0];
		u    = cy[FRACTION_BITS-1:0];
		i1x  = {1'b0, cx[FRACTION_BITS+COL_CNT_W-1:FRACTION_BITS]}
			+ {{COL_CNT_W{1'b0}}, (t != '0)};
		j1y  = {1'b0, cy[FRACTION_BITS+ROW_CNT_W-1:FRACTION_BITS]}
			+ {{ROW_CNT_W{1'b0}}, (u != '0)};
		ok_x = (cx[CW-1:FRACTION_BITS+COL_CNT_W] == '0) && (i1x < {1'b0, cols_eff});
		ok_y = (cy[CW-1:FRACTION_BITS+ROW_CNT_W] == '0) && (j1y < {1'b0, rows_eff});
		ok   = ok_x && ok_y;
		ft   = {1'b0, t};
		fu   = {1'b0, u};
		omt  = ((FRACTION_BITS + 1)'(1) << FRACTION_BITS) - ft;
		omu  = ((FRACTION_BITS + 1)'(1) << FRACTION_BITS) - fu;
		wprod[0] = omt * omu;
		wprod[1] = ft * omu;
		wprod[2] = ft * fu;
		wprod[3] = omt * fu;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK) begin
			col0_q <= cx[FRACTION_BITS+COL_IDX_W-1:FRACTION_BITS];
			col1_q <= i1x[COL_IDX_W-1:0];
			row0_q <= cy[FRACTION_BITS+ROW_IDX_W-1:FRACTION_BITS];
			row1_q <= j1y[ROW_IDX_W-1:0];
			for (int k = 0; k < NCH; k++) begin
				w_q[k] <= wprod[k][W_W-1:0];
			end
		end
	end

	// pixel memory port
	always_comb begin
		unique case (state_q)
			ST_IDLE: mem_addr = pix_addr(ROW_IDX_W'(request.row), COL_IDX_W'(request.column));
			ST_RD0:  mem_addr = pix_addr(row0_q, col0_q);
			ST_RD1:  mem_addr = pix_addr(row0_q, col1_q);
			ST_RD2:  mem_addr = pix_addr(row1_q, col1_q);
			ST_RD3:  mem_addr = pix_addr(row1_q, col0_q);
			default: mem_addr = '0;
		endcase
	end

	assign mem_we = acc_wr && wr_in_range;
	assign mem_re = (state_q == ST_RD0) || (state_q == ST_RD1) || (state_q == ST_RD2)
		|| (state_q == ST_RD3);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			pix_mem[mem_addr] <= request.pixel_argb;
		end
		if (mem_re) begin
			rd_q <= pix_mem[mem_addr];
		end
	end

	// per-channel weighted accumulation, one corner per beat of read data
	always_comb begin
		unique case (state_q)
			ST_RD1:  corner_w = w_q[0];
			ST_RD2:  corner_w = w_q[1];
			ST_RD3:  corner_w = w_q[2];
			ST_FIN:  corner_w = w_q[3];
			default: corner_w = '0;
		endcase
		for (int ch = 0; ch < NCH; ch++) begin
			prod[ch]     = corner_w * rd_q[ch*CW_W +: CW_W];
			sum_next[ch] = ((state_q == ST_RD1) ? '0 : acc_q[ch]) + prod[ch][ACC_W-1:0];
			blend_color[ch*CW_W +: CW_W] = sum_next[ch][ACC_W-1:2*FRACTION_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RD1 || state_q == ST_RD2 || state_q == ST_RD3) begin
			for (int ch = 0; ch < NCH; ch++) begin
				acc_q[ch] <= sum_next[ch];
			end
		end
		if (state_q == ST_FIN) begin
			result_q.color_argb <= blend_color;
			result_q.valid_res  <= 1'b1;
		end else if (state_q == ST_CHECK && !ok) begin
			result_q.color_argb <= bags_pkg::INVALID_COLOR;
			result_q.valid_res  <= 1'b0;
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (acc_smp) state_d = ST_COORD;
			ST_COORD: if (coord_ack) state_d = ST_CHECK;
			ST_CHECK: state_d = ok ? ST_RD0 : ST_IDLE;
			ST_RD0:   state_d = ST_RD1;
			ST_RD1:   state_d = ST_RD2;
			ST_RD2:   state_d = ST_RD3;
			ST_RD3:   state_d = ST_FIN;
			ST_FIN:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			go_q    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			go_q    <= acc_smp;
			done_q  <= (state_q == ST_FIN) || (state_q == ST_CHECK && !ok);
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while sequencer busy");

	a_invalid_color: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.valid_res |-> result.color_argb == bags_pkg::INVALID_COLOR)
		else $error("invalid result without all-ones color");

	a_valid_after_reads: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.valid_res |-> $past(state_q == ST_FIN))
		else $error("valid result not preceded by corner reads");

	a_ack_in_coord: assert property (@(posedge clk) disable iff (!arst_n)
		coord_ack |-> state_q == ST_COORD)
		else $error("coordinate unit answered outside coord phase");

	a_sample_launch: assert property (@(posedge clk) disable iff (!arst_n)
		acc_smp |=> go_q && busy)
		else $error("accepted sample did not launch coordinate unit");

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// testbench for bilinear_argb_grid_sampler: loads pixel beats and sample beats, predicts each
// color with an in-bench fixed point bilinear model and checks every done beat against it
// depends on bags_pkg and the sampler rtl
module tb;

	localparam int FB = bags_pkg::FRACTION_BITS_DEF;
	localparam int SCALE_SH = 24 - FB;
	localparam int MAX_C = bags_pkg::MAX_COLUMNS_DEF;
	localparam int MAX_R = bags_pkg::MAX_ROWS_DEF;
	localparam int CHW = bags_pkg::CH_W;
	localparam int SETTLE = 12;
	localparam int STALL_LIMIT = 2000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	logic cfg_we;
	logic [bags_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [bags_pkg::CFG_W-1:0] cfg_data;
	bags_pkg::bags_in_t request;
	bags_pkg::bags_out_t result;

	logic [31:0] pix_mem [MAX_R][MAX_C];
	bit pix_set [MAX_R][MAX_C];
	logic [8:0] grid_cols;
	logic [8:0] grid_rows;
	logic [31:0] org_x;
	logic [31:0] org_y;
	logic [31:0] inv_x;
	logic [31:0] inv_y;
	bags_pkg::bags_out_t color_due [$];
	int n_errors;
	int idle_cycles;
	int blk_w;
	int blk_h;
	bit no_gaps;

	bilinear_argb_grid_sampler dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int cols_eff();
		return (grid_cols > MAX_C) ? MAX_C : int'(grid_cols);
	endfunction

	function automatic int rows_eff();
		return (grid_rows > MAX_R) ? MAX_R : int'(grid_rows);
	endfunction

	// returns 1 when the sample would read a pixel never written
	function automatic bit predict_color(input bags_pkg::bags_in_t it,
			output bags_pkg::bags_out_t res);
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [65:0] px;
		logic signed [65:0] py;
		logic signed [69:0] cx;
		logic signed [69:0] cy;
		logic signed [69:0] i0;
		logic signed [69:0] j0;
		logic signed [69:0] i1;
		logic signed [69:0] j1;
		logic [FB-1:0] t;
		logic [FB-1:0] u;
		logic [31:0] z0;
		logic [31:0] z1;
		logic [31:0] z2;
		logic [31:0] z3;
		int nc;
		int nr;
		int w0;
		int w1;
		int w2;
		int w3;
		int acc;
		int wt;
		bit miss;
		nc = cols_eff();
		nr = rows_eff();
		wt = 1 << FB;
		miss = 1'b0;
		res.color_argb = bags_pkg::INVALID_COLOR;
		res.valid_res = 1'b0;
		dx = $signed({it.pos_x[31], it.pos_x}) - $signed({org_x[31], org_x});
		dy = $signed({it.pos_y[31], it.pos_y}) - $signed({org_y[31], org_y});
		px = dx * $signed({1'b0, inv_x});
		py = dy * $signed({1'b0, inv_y});
		cx = px >>> SCALE_SH;
		cy = (nr - 1) * wt - (py >>> SCALE_SH);
		if (cx >= 0 && cy >= 0) begin
			i0 = cx >>> FB;
			j0 = cy >>> FB;
			t = cx[FB-1:0];
			u = cy[FB-1:0];
			i1 = (t != 0) ? i0 + 1 : i0;
			j1 = (u != 0) ? j0 + 1 : j0;
			if (i1 < nc && j1 < nr) begin
				res.valid_res = 1'b1;
				z0 = pix_mem[j0[7:0]][i0[7:0]];
				if (t == 0 && u == 0) begin
					miss = !pix_set[j0[7:0]][i0[7:0]];
					res.color_argb = z0;
				end else begin
					z1 = pix_mem[j0[7:0]][i1[7:0]];
					z2 = pix_mem[j1[7:0]][i1[7:0]];
					z3 = pix_mem[j1[7:0]][i0[7:0]];
					miss = !(pix_set[j0[7:0]][i0[7:0]] && pix_set[j0[7:0]][i1[7:0]]
						&& pix_set[j1[7:0]][i1[7:0]] && pix_set[j1[7:0]][i0[7:0]]);
					w0 = (wt - t) * (wt - u);
					w1 = t * (wt - u);
					w2 = t * u;
					w3 = (wt - t) * u;
					for (int ch = 0; ch < bags_pkg::NUM_CH; ch++) begin
						acc = w0 * z0[CHW*ch +: CHW] + w1 * z1[CHW*ch +: CHW]
							+ w2 * z2[CHW*ch +: CHW] + w3 * z3[CHW*ch +: CHW];
						res.color_argb[CHW*ch +: CHW] = CHW'(acc >> (2 * FB));
					end
				end
			end
		end
		return miss;
	endfunction

	// position that lands near grid coordinate d on one axis
	function automatic logic [31:0] aim(input logic [31:0] base, input longint d,
			input logic [31:0] inv);
		if (inv == 0)
			return $urandom;
		return base + 32'((d <<< 16) / longint'(inv));
	endfunction

	function automatic bags_pkg::bags_in_t noise_item();
		bags_pkg::bags_in_t it;
		it.command = 1'($urandom_range(0, 1));
		it.column = 8'($urandom);
		it.row = 8'($urandom);
		it.pixel_argb = $urandom;
		it.pos_x = $urandom;
		it.pos_y = $urandom;
		return it;
	endfunction

	function automatic bags_pkg::bags_in_t make_write();
		bags_pkg::bags_in_t it;
		it = noise_item();
		it.command = bags_pkg::CMD_WRITE;
		if (blk_w > 0 && blk_h > 0 && $urandom_range(0, 99) < 70) begin
			it.column = 8'($urandom_range(0, blk_w - 1));
			it.row = 8'($urandom_range(0, blk_h - 1));
		end
		case ($urandom_range(0, 9))
			0: it.pixel_argb = 32'h0000_0000;
			1: it.pixel_argb = 32'hFFFF_FFFF;
			default: ;
		endcase
		return it;
	endfunction

	always @(posedge clk) begin
		bags_pkg::bags_out_t want;
		if (arst_n && done) begin
			if (color_due.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected beat, expected none, actual color %h valid %b",
					$time, result.color_argb, result.valid_res);
			end else begin
				want = color_due.pop_front();
				if (result.color_argb !== want.color_argb) begin
					n_errors++;
					$display("%0t: color_argb expected %h actual %h", $time,
						want.color_argb, result.color_argb);
				end
				if (result.valid_res !== want.valid_res) begin
					n_errors++;
					$display("%0t: valid_res expected %b actual %b", $time,
						want.valid_res, result.valid_res);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_beat(input bags_pkg::bags_in_t it);
		int gap;
		bags_pkg::bags_out_t res;
		gap = no_gaps ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			@(negedge clk) start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		request <= it;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (it.command == bags_pkg::CMD_WRITE) begin
			pix_mem[it.row][it.column] = it.pixel_argb;
			pix_set[it.row][it.column] = 1'b1;
		end else begin
			void'(predict_color(it, res));
			color_due.push_back(res);
		end
	endtask

	task automatic wait_idle();
		@(negedge clk) start <= 1'b0;
		while (color_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [bags_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk) cfg_we <= 1'b0;
		case (idx)
			bags_pkg::CFG_GRID_COLUMNS: grid_cols = val[8:0];
			bags_pkg::CFG_GRID_ROWS: grid_rows = val[8:0];
			bags_pkg::CFG_ORIGIN_X: org_x = val;
			bags_pkg::CFG_ORIGIN_Y: org_y = val;
			bags_pkg::CFG_INV_STEP_X: inv_x = val;
			bags_pkg::CFG_INV_STEP_Y: inv_y = val;
			default: ;
		endcase
	endtask

	task automatic write_pixel(input int col, input int row, input logic [31:0] val);
		bags_pkg::bags_in_t it;
		it = noise_item();
		it.command = bags_pkg::CMD_WRITE;
		it.column = 8'(col);
		it.row = 8'(row);
		it.pixel_argb = val;
		send_beat(it);
	endtask

	// skips any sample that would touch an unwritten pixel
	task automatic sample_raw(input logic [31:0] pxv, input logic [31:0] pyv);
		bags_pkg::bags_in_t it;
		bags_pkg::bags_out_t res;
		it = noise_item();
		it.command = bags_pkg::CMD_SAMPLE;
		it.pos_x = pxv;
		it.pos_y = pyv;
		if (!predict_color(it, res))
			send_beat(it);
	endtask

	// grid coordinates in 1/256 pixel, unit step reciprocals
	task automatic sample_at(input int gx, input int gy);
		sample_raw(org_x + gx, org_y + (rows_eff() - 1) * 256 - gy);
	endtask

	task automatic pick_sample(output bags_pkg::bags_in_t it, output bit ok);
		int tx;
		int ty;
		bags_pkg::bags_out_t res;
		ok = 1'b0;
		for (int k = 0; k < 40 && !ok; k++) begin
			it = noise_item();
			it.command = bags_pkg::CMD_SAMPLE;
			if ($urandom_range(0, 99) >= 12) begin
				tx = $urandom_range(0, (blk_w + 2) * 256) - 256;
				ty = $urandom_range(0, (blk_h + 2) * 256) - 256;
				case ($urandom_range(0, 3))
					0: tx = tx & ~255;
					1: ty = ty & ~255;
					2: begin
						tx = tx & ~255;
						ty = ty & ~255;
					end
					default: ;
				endcase
				it.pos_x = aim(org_x, tx, inv_x);
				it.pos_y = aim(org_y, (rows_eff() - 1) * 256 - ty, inv_y);
			end
			ok = !predict_color(it, res);
		end
	endtask

	function automatic logic [31:0] pick_count();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 9'h1FF;
			2: return MAX_C;
			3: return $urandom_range(MAX_C + 1, 511);
			default: return $urandom_range(1, 8);
		endcase
	endfunction

	function automatic logic [31:0] pick_origin();
		case ($urandom_range(0, 3))
			0, 1: return 0;
			2: return $urandom;
			default: return $urandom_range(0, 2000) - 1000;
		endcase
	endfunction

	function automatic logic [31:0] pick_inv();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 32'h0001_0000;
			4, 5, 6: return $urandom_range(4096, 1 << 20);
			7: return 0;
			8: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_pixel_blend();
		no_gaps = 1'b0;
		write_pixel(0, 0, 32'hFFFF_FFFF);
		write_pixel(1, 0, 32'h0000_0000);
		write_pixel(0, 1, 32'h80FF_007F);
		write_pixel(1, 1, $urandom);
		write_pixel(254, 254, $urandom);
		write_pixel(255, 254, $urandom);
		write_pixel(254, 255, 32'hFFFF_FFFF);
		write_pixel(255, 255, $urandom);
		sample_at(0, 0);
		sample_at(128, 64);
		sample_at(77, 0);
		sample_at(256, 200);
		sample_at(255 * 256, 255 * 256);
		sample_at(254 * 256 + 200, 254 * 256 + 17);
	endtask

	task automatic test_outside_grid();
		sample_at(255 * 256 + 1, 0);
		sample_at(-1, 0);
		sample_at(0, -1);
		sample_raw(32'h7FFF_FFFF, 32'h8000_0000);
		sample_raw(32'h8000_0000, 32'h7FFF_FFFF);
	endtask

	task automatic test_grid_limits();
		wait_idle();
		write_reg(bags_pkg::CFG_GRID_COLUMNS, 9'h1FF);
		write_reg(bags_pkg::CFG_GRID_ROWS, 300);
		sample_at(255 * 256, 255 * 256);
		wait_idle();
		write_reg(bags_pkg::CFG_GRID_COLUMNS, 0);
		sample_at(0, 0);
		wait_idle();
		write_reg(bags_pkg::CFG_GRID_COLUMNS, 2);
		write_reg(bags_pkg::CFG_GRID_ROWS, 2);
		sample_at(128, 128);
		sample_at(257, 0);
	endtask

	task automatic test_zero_step();
		wait_idle();
		write_reg(bags_pkg::CFG_INV_STEP_X, 0);
		write_reg(bags_pkg::CFG_INV_STEP_Y, 0);
		sample_raw($urandom, $urandom);
	endtask

	task automatic run_phase(input int idx, input int n_items);
		logic [31:0] nc_reg;
		logic [31:0] nr_reg;
		bags_pkg::bags_in_t it;
		bit ok;
		wait_idle();
		nc_reg = pick_count();
		nr_reg = pick_count();
		if (idx == 0) begin
			nc_reg = 1;
			nr_reg = 1;
		end else if (idx == 1) begin
			nc_reg = MAX_C;
			nr_reg = MAX_R;
		end
		write_reg(bags_pkg::CFG_GRID_COLUMNS, nc_reg);
		write_reg(bags_pkg::CFG_GRID_ROWS, nr_reg);
		write_reg(bags_pkg::CFG_ORIGIN_X, pick_origin());
		write_reg(bags_pkg::CFG_ORIGIN_Y, pick_origin());
		write_reg(bags_pkg::CFG_INV_STEP_X, pick_inv());
		write_reg(bags_pkg::CFG_INV_STEP_Y, pick_inv());
		blk_w = (cols_eff() < 6) ? cols_eff() : 6;
		blk_h = (rows_eff() < 6) ? rows_eff() : 6;
		no_gaps = ($urandom_range(0, 3) == 0);
		for (int r = 0; r < blk_h; r++)
			for (int c = 0; c < blk_w; c++)
				if (!pix_set[r][c])
					write_pixel(c, r, $urandom);
		for (int k = 0; k < n_items; k++) begin
			if ($urandom_range(0, 99) < 70) begin
				pick_sample(it, ok);
				if (!ok)
					it = make_write();
			end else begin
				it = make_write();
			end
			send_beat(it);
			if ($urandom_range(0, 99) < 3)
				wait_idle();
		end
	endtask

	task automatic test_random_phases();
		for (int p = 0; p < 10; p++)
			run_phase(p, 62);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		request = '0;
		grid_cols = 9'(MAX_C);
		grid_rows = 9'(MAX_R);
		org_x = 0;
		org_y = 0;
		inv_x = 32'h0001_0000;
		inv_y = 32'h0001_0000;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		test_pixel_blend();
		test_outside_grid();
		test_grid_limits();
		test_zero_step();
		test_random_phases();
		wait_idle();
		if (n_errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
